>>> rtl/core/sxpl_pkg.sv
// Shared types, constants and message helpers for the parameter-list SysEx translator.
package sxpl_pkg;

    // SysEx framing and header bytes
    localparam logic [7:0] SYX_START = 8'hF0;
    localparam logic [7:0] SYX_END   = 8'hF7;
    localparam logic [7:0] MFR_ID    = 8'h43;
    localparam logic [7:0] DEV_ID    = 8'h75;
    localparam logic [7:0] LIST_ID   = 8'h71;
    localparam logic [7:0] INST_BASE = 8'h18;
    localparam logic [7:0] WIDE_FLAG = 8'h40;

    // Header length in bytes and the count that marks a full match
    localparam logic [2:0] HDR_FULL  = 3'd4;

    // Byte positions inside a parameter-change message
    localparam logic [3:0] POS_START = 4'd0;
    localparam logic [3:0] POS_MFR   = 4'd1;
    localparam logic [3:0] POS_DEV   = 4'd2;
    localparam logic [3:0] POS_NODE  = 4'd3;
    localparam logic [3:0] POS_INST  = 4'd4;
    localparam logic [3:0] POS_PARAM = 4'd5;
    localparam logic [3:0] POS_VAL0  = 4'd6;
    localparam logic [3:0] POS_VAL1  = 4'd7;

    // Run lengths
    localparam logic [3:0] LEN_PASS   = 4'd1;
    localparam logic [3:0] LEN_NARROW = 4'd8;
    localparam logic [3:0] LEN_WIDE   = 4'd9;

    // Kind of output run that one input word produces
    typedef enum logic [1:0] {
        JOB_PASS  = 2'd0,
        JOB_ABORT = 2'd1,
        JOB_MSG   = 2'd2
    } job_kind_t;

    // One queued output run
    typedef struct packed {
        job_kind_t   kind;
        logic [7:0]  data;    // passed byte, breaking byte, or first value byte
        logic [1:0]  hcnt;    // header bytes matched before a mismatch
        logic [3:0]  node;
        logic [2:0]  inst;
        logic [5:0]  prm;
        logic        wide;
        logic [7:0]  val_b;   // second value byte of a wide entry
    } job_t;

    // Expected header byte at a match position
    function automatic logic [7:0] hdr_byte(input logic [1:0] pos);
        logic [7:0] b;
        case (pos)
            2'd0:    b = SYX_START;
            2'd1:    b = MFR_ID;
            2'd2:    b = DEV_ID;
            2'd3:    b = LIST_ID;
            default: b = SYX_START;
        endcase
        return b;
    endfunction

    // Number of output words in a run
    function automatic logic [3:0] job_len(input job_t job);
        logic [3:0] n;
        case (job.kind)
            JOB_PASS:  n = LEN_PASS;
            JOB_ABORT: n = {2'b00, job.hcnt} + 4'd1;
            JOB_MSG:   n = job.wide ? LEN_WIDE : LEN_NARROW;
            default:   n = LEN_PASS;
        endcase
        return n;
    endfunction

    // Output word at a position within a run
    function automatic logic [7:0] job_byte(input job_t job, input logic [3:0] idx);
        logic [7:0] b;
        b = job.data;
        case (job.kind)
            JOB_PASS: b = job.data;
            JOB_ABORT:
            begin
                if (idx < {2'b00, job.hcnt})
                    b = hdr_byte(idx[1:0]);
                else
                    b = job.data;
            end
            JOB_MSG:
            begin
                case (idx)
                    POS_START: b = SYX_START;
                    POS_MFR:   b = MFR_ID;
                    POS_DEV:   b = DEV_ID;
                    POS_NODE:  b = {4'h0, job.node};
                    POS_INST:  b = INST_BASE | {5'b00000, job.inst};
                    POS_PARAM: b = {1'b0, job.wide, job.prm};
                    POS_VAL0:  b = job.data;
                    POS_VAL1:  b = job.wide ? job.val_b : SYX_END;
                    default:   b = SYX_END;
                endcase
            end
            default: b = job.data;
        endcase
        return b;
    endfunction

endpackage

>>> rtl/core/sxpl_front.sv
// Front end: accepts input words, tracks SysEx header and entry state, builds output runs.
module sxpl_front
    import sxpl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       take,        // input word accepted this cycle
    input  logic [7:0] data_byte,
    input  logic       restart,
    output logic       push,
    output job_t       push_job
);

    logic       in_sysex_reg, in_sysex_next;
    logic       translating_reg, translating_next;
    logic [2:0] header_count_reg, header_count_next;
    logic [2:0] param_count_reg, param_count_next;
    logic [7:0] param_bytes_reg [4];

    logic       wr_en;
    logic [1:0] wr_idx;
    logic [7:0] ent [4];
    logic [2:0] pc_inc;
    logic       ent_wide;

    // Entry bytes with the incoming word forwarded into its slot
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            if (param_count_reg[1:0] == 2'(i))
                ent[i] = data_byte;
            else
                ent[i] = param_bytes_reg[i];
        end
    end

    assign ent_wide = (ent[1] & WIDE_FLAG) != 8'h00;

    // Classify the word and compute the next state
    always_comb
    begin
        in_sysex_next     = in_sysex_reg;
        translating_next  = translating_reg;
        header_count_next = header_count_reg;
        param_count_next  = param_count_reg;
        wr_en             = 1'b0;
        wr_idx            = 2'd0;
        pc_inc            = 3'd0;
        push              = 1'b0;
        push_job          = '0;
        push_job.kind     = JOB_PASS;
        push_job.data     = data_byte;

        if (restart)
        begin
            in_sysex_next     = 1'b0;
            translating_next  = 1'b0;
            header_count_next = 3'd0;
            param_count_next  = 3'd0;
        end
        if (data_byte == SYX_START)
        begin
            in_sysex_next     = 1'b1;
            translating_next  = 1'b0;
            header_count_next = 3'd0;
        end

        if (!in_sysex_next)
        begin
            // pass through
            push = 1'b1;
        end
        else if (header_count_next < HDR_FULL)
        begin
            if (hdr_byte(header_count_next[1:0]) == data_byte)
            begin
                header_count_next = header_count_next + 3'd1;
                if (header_count_next == HDR_FULL)
                begin
                    translating_next = 1'b1;
                    param_count_next = 3'd0;
                end
            end
            else
            begin
                // header broken: replay matched prefix, then the word
                in_sysex_next    = 1'b0;
                translating_next = 1'b0;
                push             = 1'b1;
                push_job.kind    = JOB_ABORT;
                push_job.hcnt    = header_count_next[1:0];
            end
        end
        else if (!translating_next)
        begin
            // drop
        end
        else if (data_byte == SYX_END)
        begin
            in_sysex_next    = 1'b0;
            translating_next = 1'b0;
        end
        else
        begin
            // collect entry byte
            wr_en            = 1'b1;
            wr_idx           = param_count_next[1:0];
            pc_inc           = param_count_next + 3'd1;
            param_count_next = pc_inc;
            if (pc_inc >= 3'd3 && (!ent_wide || pc_inc >= 3'd4))
            begin
                push             = 1'b1;
                push_job.kind    = JOB_MSG;
                push_job.node    = ent[0][3:0];
                push_job.inst    = ent[0][6:4];
                push_job.prm     = ent[1][5:0];
                push_job.wide    = ent_wide;
                push_job.data    = ent[2];
                push_job.val_b   = ent[3];
                param_count_next = 3'd0;
            end
        end

        if (!take)
            push = 1'b0;
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_sysex_reg     <= 1'b0;
            translating_reg  <= 1'b0;
            header_count_reg <= 3'd0;
            param_count_reg  <= 3'd0;
        end
        else if (take)
        begin
            in_sysex_reg     <= in_sysex_next;
            translating_reg  <= translating_next;
            header_count_reg <= header_count_next;
            param_count_reg  <= param_count_next;
        end
    end

    // Store entry bytes
    always_ff @(posedge clk)
    begin
        if (take && wr_en)
            param_bytes_reg[wr_idx] <= data_byte;
    end

endmodule

>>> rtl/core/sxpl_queue.sv
// Short queue of output runs between the front end and the serializer.
module sxpl_queue
    import sxpl_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic full,
    output logic head_valid,
    output job_t head_job,
    input  logic pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full       = count_reg == CNT_W'(DEPTH);
    assign head_valid = count_reg != '0;
    assign head_job   = slot_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // Advance pointers and count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Write slot
    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_job;
    end

endmodule

>>> rtl/core/sxpl_back.sv
// Back end: serializes queued runs into output words through an output register.
module sxpl_back
    import sxpl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       head_valid,
    input  job_t       head_job,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       last_of_run
);

    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_byte_reg;
    logic       last_reg;
    logic [3:0] idx_reg, idx_next;
    logic       load;
    logic       at_end;

    assign load   = head_valid && (!out_valid_reg || out_ready);
    assign at_end = idx_reg == (job_len(head_job) - 4'd1);
    assign pop    = load && at_end;

    // Step through the run
    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            idx_next       = at_end ? 4'd0 : idx_reg + 4'd1;
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= 4'd0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
        end
    end

    // Load output word
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_byte_reg <= job_byte(head_job, idx_reg);
            last_reg     <= at_end;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign last_of_run = last_reg;

endmodule

>>> rtl/core/sysex_param_list_translator.sv
// Top level of the parameter-list SysEx translator.
//
// Input channel: data_byte and restart move under in_valid/in_ready; one word
// is one MIDI byte. Output channel: out_byte and last_of_run move under
// out_valid/out_ready; last_of_run marks the final word produced for an input.
// An input word causes 0, 1, 2 to 4 (broken header) or 8 to 9 (entry message)
// output words. The front end classifies a word in the cycle it is accepted
// and queues a run; the serializer then loads the first output word of the run
// into the output register. While out_ready is high, the serializer emits one
// word per cycle, so the output rate is set by the output register: pass-through
// words flow at one per cycle, and an entry message occupies 8 or 9 output words.
// in_ready drops only while the run queue (QUEUE_DEPTH runs) is full.
// When the receiver stalls, the current word holds in the output register and
// the queue fills; the input then stalls in turn. Reset clears SysEx and
// header tracking, the entry count, the queue and the output valid flag.
module sysex_param_list_translator
    import sxpl_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] data_byte,
    input  logic       restart,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       last_of_run
);

    logic take;
    logic push;
    job_t push_job;
    logic full;
    logic head_valid;
    job_t head_job;
    logic pop;

    assign in_ready = !full;
    assign take     = in_valid && in_ready;

    sxpl_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .data_byte (data_byte),
        .restart   (restart),
        .push      (push),
        .push_job  (push_job)
    );

    sxpl_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .full       (full),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop)
    );

    sxpl_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (head_valid),
        .head_job    (head_job),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .last_of_run (last_of_run)
    );

endmodule
